// ===== hw/rtl/ges_pkg.sv =====
package ges_pkg;

  localparam int DEF_MAX_CATEGORIES = 32;
  localparam int DEF_MAX_SAMPLES    = 64;
  localparam int ACC_W              = 48;

  typedef enum logic [0:0] {
    REG_NUM_SAMPLES    = 1'b0,
    REG_NUM_CATEGORIES = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [4:0]         category;
    logic signed [31:0] sample_value;
    logic signed [31:0] observed_value;
    logic               end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_category;
    logic signed [31:0] score;
    logic signed [31:0] overall_mean;
    logic               last;
  } out_item_t;

  typedef struct packed {
    reg_index_t index;
    logic [6:0] value;
  } cfg_item_t;

  // Saturating Q32.16 square of an exact 33 bit difference.
  function automatic logic [ACC_W-1:0] sq_term(input logic signed [32:0] d);
    logic [32:0] mag;
    logic [63:0] prod;
    mag  = d[32] ? 33'(-d) : 33'(d);
    prod = 64'(mag[31:0]) * 64'(mag[31:0]);
    if (mag[32]) begin
      return '1;
    end
    return prod[63:16];
  endfunction

endpackage

// ===== hw/rtl/ges_stream_if.sv =====
interface ges_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/grouped_energy_score_unit.sv =====
// Grouped energy score unit. Samples stream in on "in"; each passes the accept
// state, a state that reads the two accumulators of the sample's category and
// position from their RAMs while squaring the deviation and the step, and a
// state that writes the saturated sums back, before the next one is accepted.
// The item marked end_of_data starts scoring, or, with no categories set, the
// clearing pass. For each category the unit walks its S table positions, each
// through the bit-serial square root pair (one root bit per step, 32 steps).
// Two quotients per category, plus the mean on the last category, each take
// one restoring divider pass of one cycle per dividend bit, the dividend being
// the wider of the root sum (32+log2(MAX_SAMPLES) bits) and the score total
// (33+ceil(log2(MAX_CATEGORIES+1)) bits), 39 bits at the defaults, followed by
// a state that takes the quotient. Results leave through a registered output
// and wait for the sink. After reset and after every run a clearing pass
// zeroes both RAMs, one entry per cycle over all
// 2^(log2(MAX_CATEGORIES)+log2(MAX_SAMPLES)) entries (2048 at the defaults);
// no sample is accepted meanwhile, configuration writes are always taken.
module grouped_energy_score_unit #(
  parameter int MAX_CATEGORIES = ges_pkg::DEF_MAX_CATEGORIES,
  parameter int MAX_SAMPLES    = ges_pkg::DEF_MAX_SAMPLES
) (
  input logic   clk,
  input logic   rst,
  ges_stream_if.sink   in,
  ges_stream_if.source out,
  ges_stream_if.sink   cfg
);
  import ges_pkg::*;

  localparam int CW    = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int SW    = $clog2(MAX_SAMPLES);
  localparam int AW    = CW + SW;
  localparam int DEPTH = 1 << AW;
  localparam int CNW   = $clog2(MAX_CATEGORIES + 1);
  localparam int SUMW  = 32 + SW;
  localparam int TOTW  = 33 + CNW;
  localparam int DIVW  = (SUMW > TOTW) ? SUMW : TOTW;
  localparam int DENW  = 10;
  localparam int NIT   = (DIVW > 32) ? DIVW : 32;
  localparam int ITW   = $clog2(NIT + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_WR, S_SC_RD, S_SC_LD, S_SQRT, S_SC_ACC,
    S_DIV, S_DIV_DONE, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DP_A, DP_B, DP_M
  } div_phase_t;

  state_t     state;
  div_phase_t div_phase;

  logic [6:0] num_samples;
  logic [5:0] num_categories;
  logic [8:0] s_eff;
  logic [6:0] c_eff;

  // load path registers
  logic [SW-1:0]      pos;
  logic signed [31:0] prev;
  logic [AW-1:0]      ld_dev_addr, ld_step_addr;
  logic               ld_valid, ld_has_step, ld_eod;
  logic signed [32:0] d_dev, d_step;
  logic [ACC_W-1:0]   term_dev, term_step;

  // memories
  logic [ACC_W-1:0] dev_mem  [DEPTH];
  logic [ACC_W-1:0] step_mem [DEPTH];
  logic [ACC_W-1:0] dev_rd, step_rd;
  logic [AW-1:0]    rd_dev_addr, rd_step_addr, wr_dev_addr, wr_step_addr;
  logic [ACC_W-1:0] wr_dev_data, wr_step_data;
  logic             wr_dev_en, wr_step_en;
  logic [AW-1:0]    clr_addr;

  // scoring registers
  logic [CNW-1:0]     j;
  logic [8:0]         s;
  logic [SUMW-1:0]    sum_a, sum_b;
  logic [63:0]        sq_x_d, sq_x_s;
  logic [33:0]        sq_rem_d, sq_rem_s;
  logic [31:0]        sq_root_d, sq_root_s;
  logic               step_used;
  logic [ITW-1:0]     it;
  logic [DIVW-1:0]    div_q, qa;
  logic [DENW:0]      div_rem;
  logic [DENW-1:0]    div_den;
  logic               mean_neg;
  logic signed [TOTW-1:0] total;
  out_item_t          res;
  logic               res_valid;

  // combinational helpers
  logic [8:0]         p_cur, p_inc;
  logic [7:0]         catx;
  logic [33:0]        sq_sh_d, sq_sh_s, sq_tr_d, sq_tr_s;
  logic               sq_ge_d, sq_ge_s;
  logic [DENW:0]      div_sh;
  logic               div_ge;
  logic signed [DIVW+1:0] sc_wide;
  logic signed [31:0] sc32;
  logic signed [TOTW-1:0] total_new;
  logic [7:0]         jx;
  logic               j_last;

  assign cfg.ready = 1'b1;
  assign in.ready  = (state == S_IDLE);
  assign out.valid = res_valid;
  assign out.data  = res;

  always_comb begin
    s_eff = 9'(num_samples);
    if (s_eff < 9'd2) begin
      s_eff = 9'd2;
    end else if (s_eff > 9'(MAX_SAMPLES)) begin
      s_eff = 9'(MAX_SAMPLES);
    end
    c_eff = 7'(num_categories);
    if (c_eff > 7'(MAX_CATEGORIES)) begin
      c_eff = 7'(MAX_CATEGORIES);
    end
    p_cur = (9'(pos) >= s_eff) ? 9'd0 : 9'(pos);
    p_inc = p_cur + 9'd1;
    catx  = 8'(in.data.category);
    jx    = 8'(j);
    j_last = (7'(j) == c_eff - 7'd1);
  end

  always_comb begin
    sq_sh_d = {sq_rem_d[31:0], sq_x_d[63:62]};
    sq_sh_s = {sq_rem_s[31:0], sq_x_s[63:62]};
    sq_tr_d = {sq_root_d, 2'b01};
    sq_tr_s = {sq_root_s, 2'b01};
    sq_ge_d = (sq_sh_d >= sq_tr_d);
    sq_ge_s = (sq_sh_s >= sq_tr_s);
    div_sh  = {div_rem[DENW-1:0], div_q[DIVW-1]};
    div_ge  = (div_sh >= {1'b0, div_den});
    sc_wide = $signed({2'b00, qa}) - $signed({2'b00, div_q});
    if (sc_wide > (DIVW+2)'(32'sh7fffffff)) begin
      sc32 = 32'sh7fffffff;
    end else if (sc_wide < -(DIVW+2)'(33'sh080000000)) begin
      sc32 = 32'sh80000000;
    end else begin
      sc32 = sc_wide[31:0];
    end
    total_new = total + TOTW'(sc32);
  end

  always_comb begin
    rd_dev_addr  = ld_dev_addr;
    rd_step_addr = ld_step_addr;
    if (state != S_MUL) begin
      rd_dev_addr  = {j[CW-1:0], s[SW-1:0]};
      rd_step_addr = {j[CW-1:0], s[SW-1:0]};
    end
    wr_dev_en    = (state == S_CLEAR) || (state == S_WR && ld_valid);
    wr_step_en   = (state == S_CLEAR) || (state == S_WR && ld_valid && ld_has_step);
    wr_dev_addr  = (state == S_CLEAR) ? clr_addr : ld_dev_addr;
    wr_step_addr = (state == S_CLEAR) ? clr_addr : ld_step_addr;
    wr_dev_data  = '0;
    wr_step_data = '0;
    if (state != S_CLEAR) begin
      wr_dev_data  = ((49'(dev_rd) + 49'(term_dev)) > 49'({ACC_W{1'b1}})) ?
                     '1 : dev_rd + term_dev;
      wr_step_data = ((49'(step_rd) + 49'(term_step)) > 49'({ACC_W{1'b1}})) ?
                     '1 : step_rd + term_step;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_dev_en) begin
      dev_mem[wr_dev_addr] <= wr_dev_data;
    end
    dev_rd <= dev_mem[rd_dev_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_step_en) begin
      step_mem[wr_step_addr] <= wr_step_data;
    end
    step_rd <= step_mem[rd_step_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples    <= 7'd2;
      num_categories <= 6'd1;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_NUM_SAMPLES:    num_samples    <= cfg.data.value;
        REG_NUM_CATEGORIES: num_categories <= 6'(cfg.data.value);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      pos       <= '0;
      prev      <= '0;
      total     <= '0;
      div_phase <= DP_A;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in.valid) begin
            ld_valid     <= (catx < 8'(MAX_CATEGORIES));
            ld_dev_addr  <= {catx[CW-1:0], p_cur[SW-1:0]};
            ld_step_addr <= {catx[CW-1:0], SW'(p_cur - 9'd1)};
            ld_has_step  <= (p_cur != 9'd0);
            ld_eod       <= in.data.end_of_data;
            d_dev  <= 33'(in.data.sample_value) - 33'(in.data.observed_value);
            d_step <= 33'(in.data.sample_value) - 33'(prev);
            prev   <= in.data.sample_value;
            pos    <= (p_inc >= s_eff) ? '0 : SW'(p_inc);
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          term_dev  <= sq_term(d_dev);
          term_step <= sq_term(d_step);
          state     <= S_WR;
        end
        S_WR: begin
          if (!ld_eod) begin
            state <= S_IDLE;
          end else begin
            j     <= '0;
            s     <= '0;
            sum_a <= '0;
            sum_b <= '0;
            total <= '0;
            if (c_eff == 7'd0) begin
              clr_addr <= '0;
              pos      <= '0;
              prev     <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_SC_RD;
            end
          end
        end
        S_SC_RD: begin
          state <= S_SC_LD;
        end
        S_SC_LD: begin
          sq_x_d    <= {dev_rd, 16'd0};
          sq_x_s    <= {step_rd, 16'd0};
          sq_rem_d  <= '0;
          sq_rem_s  <= '0;
          sq_root_d <= '0;
          sq_root_s <= '0;
          step_used <= (s < s_eff - 9'd1);
          it        <= '0;
          state     <= S_SQRT;
        end
        S_SQRT: begin
          sq_x_d    <= {sq_x_d[61:0], 2'b00};
          sq_x_s    <= {sq_x_s[61:0], 2'b00};
          sq_rem_d  <= sq_ge_d ? sq_sh_d - sq_tr_d : sq_sh_d;
          sq_rem_s  <= sq_ge_s ? sq_sh_s - sq_tr_s : sq_sh_s;
          sq_root_d <= {sq_root_d[30:0], sq_ge_d};
          sq_root_s <= {sq_root_s[30:0], sq_ge_s};
          it        <= it + ITW'(1);
          if (it == ITW'(31)) begin
            state <= S_SC_ACC;
          end
        end
        S_SC_ACC: begin
          sum_a <= sum_a + SUMW'(sq_root_d);
          if (step_used) begin
            sum_b <= sum_b + SUMW'(sq_root_s);
          end
          s <= s + 9'd1;
          if (s + 9'd1 == s_eff) begin
            div_q     <= DIVW'(sum_a + SUMW'(sq_root_d));
            div_den   <= DENW'(s_eff);
            div_rem   <= '0;
            div_phase <= DP_A;
            it        <= '0;
            state     <= S_DIV;
          end else begin
            state <= S_SC_RD;
          end
        end
        S_DIV: begin
          div_q   <= {div_q[DIVW-2:0], div_ge};
          div_rem <= div_ge ? div_sh - {1'b0, div_den} : div_sh;
          it      <= it + ITW'(1);
          if (it == ITW'(DIVW - 1)) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          div_rem <= '0;
          it      <= '0;
          priority case (div_phase)
            DP_A: begin
              qa        <= div_q;
              div_q     <= DIVW'(sum_b);
              div_den   <= DENW'({s_eff - 9'd1, 1'b0});
              div_phase <= DP_B;
              state     <= S_DIV;
            end
            DP_B: begin
              total            <= total_new;
              res.out_category <= jx[4:0];
              res.score        <= sc32;
              res.overall_mean <= '0;
              res.last         <= 1'b0;
              if (j_last) begin
                mean_neg  <= total_new[TOTW-1];
                div_q     <= DIVW'(total_new[TOTW-1] ? -total_new : total_new);
                div_den   <= DENW'(c_eff);
                div_phase <= DP_M;
                state     <= S_DIV;
              end else begin
                res_valid <= 1'b1;
                state     <= S_EMIT;
              end
            end
            default: begin
              res.overall_mean <= mean_neg ? -div_q[31:0] : div_q[31:0];
              res.last         <= 1'b1;
              res_valid        <= 1'b1;
              state            <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (out.ready) begin
            res_valid <= 1'b0;
            if (res.last) begin
              clr_addr <= '0;
              pos      <= '0;
              prev     <= '0;
              total    <= '0;
              state    <= S_CLEAR;
            end else begin
              j     <= j + CNW'(1);
              s     <= '0;
              sum_a <= '0;
              sum_b <= '0;
              state <= S_SC_RD;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> state == S_EMIT)
    else $error("result valid outside emit");
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> state == S_MUL)
    else $error("accepted sample not processed");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(res)))
    else $error("stalled result changed");
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR && clr_addr == '0))
    else $error("reset did not start clearing pass");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  import ges_pkg::*;

  localparam int NCAT = DEF_MAX_CATEGORIES;
  localparam int NSMP = DEF_MAX_SAMPLES;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst;

  ges_stream_if #(.T(in_item_t))  in_if ();
  ges_stream_if #(.T(out_item_t)) out_if ();
  ges_stream_if #(.T(cfg_item_t)) cfg_if ();

  grouped_energy_score_unit uut (
    .clk(clk),
    .rst(rst),
    .in(in_if),
    .out(out_if),
    .cfg(cfg_if)
  );

  always #1 clk = ~clk;

  // Shadow of the unit's accumulator tables and run state
  logic [ACC_W-1:0]   dev_acc [NCAT][NSMP];
  logic [ACC_W-1:0]   step_acc[NCAT][NSMP];
  logic signed [31:0] prev_smp;
  int                 smp_pos;
  logic [6:0]         samples_reg;
  logic [5:0]         cats_reg;

  in_item_t  sample_q[$];
  out_item_t score_q[$];
  int        idle_pct;
  int        errors;
  int        n_in, n_out, n_runs;
  int        stall_cnt;

  function automatic logic [ACC_W-1:0] sq_dev(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    logic [65:0]        p;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? -d : d;
    if (m[32]) return {ACC_W{1'b1}};
    p = m * m;
    return p[63:16];
  endfunction

  function automatic logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] t);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, t};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_tables();
    for (int c = 0; c < NCAT; c++)
      for (int s = 0; s < NSMP; s++) begin
        dev_acc[c][s]  = '0;
        step_acc[c][s] = '0;
      end
    prev_smp = '0;
    smp_pos  = 0;
  endtask

  // Accumulate one sample and, on end of data, queue the category scores
  task automatic absorb_sample(in_item_t it);
    int               ns, nc, p;
    longint unsigned  ra, rb;
    longint           sc, total;
    out_item_t        r;
    ns = samples_reg;
    nc = cats_reg;
    if (ns < 2) ns = 2;
    if (ns > NSMP) ns = NSMP;
    if (nc > NCAT) nc = NCAT;
    p = smp_pos;
    if (p >= ns) p = 0;
    if (it.category < NCAT) begin
      dev_acc[it.category][p] = acc_add(dev_acc[it.category][p],
                                        sq_dev(it.sample_value, it.observed_value));
      if (p >= 1)
        step_acc[it.category][p-1] = acc_add(step_acc[it.category][p-1],
                                             sq_dev(it.sample_value, prev_smp));
    end
    prev_smp = it.sample_value;
    p++;
    smp_pos = (p >= ns) ? 0 : p;
    if (!it.end_of_data) return;
    n_runs++;
    total = 0;
    for (int j = 0; j < nc; j++) begin
      ra = 0;
      rb = 0;
      for (int s = 0; s < ns; s++) ra += int_sqrt({16'h0, dev_acc[j][s]} << 16);
      for (int s = 0; s + 1 < ns; s++) rb += int_sqrt({16'h0, step_acc[j][s]} << 16);
      sc = longint'(ra / ns) - longint'(rb / (2 * (ns - 1)));
      if (sc > 64'sd2147483647) sc = 64'sd2147483647;
      if (sc < -64'sd2147483648) sc = -64'sd2147483648;
      total += sc;
      r.out_category = j[4:0];
      r.score        = sc[31:0];
      r.overall_mean = '0;
      r.last         = 1'b0;
      if (j == nc - 1) begin
        total = total / nc;
        r.overall_mean = total[31:0];
        r.last = 1'b1;
      end
      score_q.push_back(r);
    end
    clear_tables();
  endtask

  // Sample stream driver
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= sample_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.index == REG_NUM_SAMPLES) samples_reg <= cfg_if.data.value;
        else cats_reg <= cfg_if.data.value[5:0];
      end
      if (in_if.valid && in_if.ready) begin
        absorb_sample(in_if.data);
        n_in++;
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (score_q.size() == 0) begin
          $error("unexpected result: category %0d", out_if.data.out_category);
          errors++;
        end else begin
          out_item_t e;
          e = score_q.pop_front();
          if (out_if.data.out_category !== e.out_category) begin
            $error("out_category: expected %0d actual %0d", e.out_category,
                   out_if.data.out_category);
            errors++;
          end
          if (out_if.data.score !== e.score) begin
            $error("score: expected %h actual %h", e.score, out_if.data.score);
            errors++;
          end
          if (out_if.data.overall_mean !== e.overall_mean) begin
            $error("overall_mean: expected %h actual %h", e.overall_mean,
                   out_if.data.overall_mean);
            errors++;
          end
          if (out_if.data.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_if.data.last);
            errors++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) ||
          (sample_q.size() == 0 && score_q.size() == 0 && !in_if.valid)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("grouped_energy_score_unit verification failed");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(reg_index_t idx, int val);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= val[6:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle(int extra);
    while (sample_q.size() > 0 || in_if.valid || score_q.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000))) - 32'sd1000;
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'h8000_0000 + $urandom_range(3);
      default: return $signed($urandom_range(32'h40000)) - 32'sd131072;
    endcase
  endfunction

  task automatic push_sample(int cat, logic [31:0] smp, logic [31:0] obs, bit eod);
    in_item_t it;
    it.category       = cat[4:0];
    it.sample_value   = smp;
    it.observed_value = obs;
    it.end_of_data    = eod;
    sample_q.push_back(it);
  endtask

  // Well-formed observations with random content; a few are broken on purpose
  task automatic queue_run(int ns, int nc, int nobs);
    logic [31:0] obs, smp;
    int          cat, cut;
    cut = ($urandom_range(9) == 0) ? $urandom_range(ns - 1) : ns;
    for (int o = 0; o < nobs; o++) begin
      cat = ($urandom_range(7) == 0 || nc == 0) ? $urandom_range(31)
                                                : $urandom_range(nc - 1);
      obs = pick_value();
      for (int s = 0; s < ns; s++) begin
        if ($urandom_range(19) == 0) cat = $urandom_range(31);
        if ($urandom_range(19) == 0) obs = pick_value();
        smp = ($urandom_range(3) == 0) ? pick_value() : obs + $urandom_range(32'h30000) - 32'h18000;
        if (o == nobs - 1 && (s == ns - 1 || s == cut)) begin
          push_sample(cat, smp, obs, 1'b1);
          return;
        end
        push_sample(cat, smp, obs, 1'b0);
      end
    end
  endtask

  initial begin
    int ns, nc;
    rst = 1'b1;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    idle_pct = 30;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_runs = 0;
    stall_cnt = 0;
    samples_reg = 7'd2;
    cats_reg = 6'd1;
    clear_tables();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: field extremes, saturation, end of data mid observation
    push_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(31, 32'hFFFF_FFFF, 32'h0, 1'b0);
    push_sample(31, 32'h0, 32'hFFFF_FFFF, 1'b0);
    push_sample(0, 32'h0001_0000, 32'h0, 1'b1);
    push_sample(0, 32'h0, 32'h0, 1'b0);
    push_sample(0, 32'h0, 32'h0, 1'b1);
    push_sample(21, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push_sample(10, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    settle(10);

    // Sample count below range, no categories emitted
    write_reg(REG_NUM_SAMPLES, 1);
    write_reg(REG_NUM_CATEGORIES, 0);
    push_sample(0, 32'h0002_0000, 32'h0, 1'b0);
    push_sample(0, 32'h0, 32'h0002_0000, 1'b0);
    push_sample(3, 32'h1234_5678, 32'h0, 1'b1);
    settle(3000);

    // Leave a partial observation, then shrink S so the position wraps
    write_reg(REG_NUM_SAMPLES, 5);
    write_reg(REG_NUM_CATEGORIES, 63);
    for (int k = 0; k < 9; k++) push_sample(k % 3, pick_value(), pick_value(), 1'b0);
    settle(20);
    write_reg(REG_NUM_SAMPLES, 3);
    for (int k = 0; k < 3; k++) push_sample(1, pick_value(), 32'h0, k == 2);
    settle(10);

    // Random runs at small sizes, one of them with all 32 categories
    for (int r = 0; r < 10; r++) begin
      idle_pct = (r >= 4 && r < 7) ? 0 : 30;
      ns = $urandom_range(2, 6);
      nc = $urandom_range(1, 8);
      if (r == 2) nc = 32;
      write_reg(REG_NUM_SAMPLES, ns);
      write_reg(REG_NUM_CATEGORIES, nc);
      queue_run(ns, nc, $urandom_range(1, 3));
      settle(10);
    end
    idle_pct = 30;

    // Largest sizes: S at maximum and clamped from above
    write_reg(REG_NUM_SAMPLES, 64);
    write_reg(REG_NUM_CATEGORIES, 2);
    for (int k = 0; k < 6; k++) push_sample(k % 2, pick_value(), pick_value(), k == 5);
    settle(10);
    write_reg(REG_NUM_SAMPLES, 127);
    write_reg(REG_NUM_CATEGORIES, 32);
    for (int k = 0; k < 6; k++) push_sample($urandom_range(31), pick_value(), pick_value(), k == 5);
    settle(100);

    $display("Covered %0d samples over %0d scoring runs, %0d scores checked.",
             n_in, n_runs, n_out);
    $display("Settings spanned S of 1 to 127 and category counts of 0 to 63.");
    if (errors == 0 && score_q.size() == 0) begin
      $display("grouped_energy_score_unit verification clean");
    end else begin
      $display("grouped_energy_score_unit verification failed");
    end
    $finish;
  end

endmodule
